/* design/lssd_pkg.sv */
// Shared types and constants for the LSB stego stream decoder.
`timescale 1ns / 1ps

package lssd_pkg;

    // Default build values
    localparam int EXT_BYTES_DEF     = 4;
    localparam int SIZE_BITS_DEF     = 32;
    localparam int MAX_SIGNATURE_DEF = 8;

    // Fixed field widths
    localparam int BYTE_W     = 8;
    localparam int HDR_LEN_W  = 8;
    localparam int SIG_LEN_W  = 4;
    localparam int SIG_CHAR_W = 64;
    localparam int VALUE_W    = 32;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int SIG_SEL_W  = 3;

    // Reset values of the configuration registers
    localparam logic [HDR_LEN_W-1:0]  HDR_LEN_RST  = 8'd54;
    localparam logic [SIG_LEN_W-1:0]  SIG_LEN_RST  = 4'd2;
    localparam logic [SIG_CHAR_W-1:0] SIG_CHAR_RST = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEADER_LENGTH    = 2'd0,
        REG_SIGNATURE_LENGTH = 2'd1,
        REG_SIGNATURE_CHARS  = 2'd2
    } cfg_reg_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_EXT  = 2'd0,
        KIND_DATA = 2'd1,
        KIND_SIZE = 2'd2,
        KIND_ERR  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_MAGIC  = 3'd1,
        PH_EXT    = 3'd2,
        PH_SIZE   = 3'd3,
        PH_DATA   = 3'd4,
        PH_IDLE   = 3'd5
    } phase_t;

    typedef struct packed {
        logic [HDR_LEN_W-1:0]  header_length;
        logic [SIG_LEN_W-1:0]  signature_length;
        logic [SIG_CHAR_W-1:0] signature_chars;
    } cfg_t;

    typedef struct packed {
        logic                valid;
        kind_t               kind;
        logic [VALUE_W-1:0]  value;
        logic                last;
    } res_t;

endpackage

/* design/lsb_stego_stream_decoder.sv */
// Top level of the LSB stego stream decoder: channel registers and config.
//
//  channel | dir | payload                                   | handshake
//  s_      | in  | tdata=image_byte, tuser=frame_start       | s_tvalid/s_tready
//  m_      | out | tdata=value, tuser=kind, tlast=last       | m_tvalid/m_tready
//  cfg_    | in  | cfg_index, cfg_data                       | cfg_valid/cfg_ready
//
// One image byte per cycle while the output is not stalled: each transaction is registered,
// then parsed, and its result (if any) is in the output register at the end of the parse cycle.
// aresetn is synchronous; it restores the register defaults and the header-skip phase.
// A stalled output holds the parser; the input register still takes one transaction.
`timescale 1ns / 1ps

module lsb_stego_stream_decoder #(
    parameter int EXT_BYTES     = lssd_pkg::EXT_BYTES_DEF,
    parameter int SIZE_BITS     = lssd_pkg::SIZE_BITS_DEF,
    parameter int MAX_SIGNATURE = lssd_pkg::MAX_SIGNATURE_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lssd_pkg::BYTE_W-1:0]       s_tdata,   // [7:0] image_byte
    input  logic                              s_tuser,   // [0] frame_start
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lssd_pkg::VALUE_W-1:0]      m_tdata,   // [31:0] value
    output logic [lssd_pkg::KIND_W-1:0]       m_tuser,   // [1:0] kind
    output logic                              m_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lssd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lssd_pkg::SIG_CHAR_W-1:0]   cfg_data
);
    import lssd_pkg::*;

    cfg_t                cfg_reg, cfg_next;
    logic                in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0]   in_byte_reg;
    logic                in_start_reg;
    logic                out_valid_reg, out_valid_next;
    kind_t               out_kind_reg;
    logic [VALUE_W-1:0]  out_value_reg;
    logic                out_last_reg;

    logic                out_free;
    logic                step;
    logic                s_accept;
    res_t                res;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;
    assign step      = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign s_accept  = s_tvalid && s_tready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_HEADER_LENGTH:    cfg_next.header_length    = cfg_data[HDR_LEN_W-1:0];
                REG_SIGNATURE_LENGTH: cfg_next.signature_length = cfg_data[SIG_LEN_W-1:0];
                REG_SIGNATURE_CHARS:  cfg_next.signature_chars  = cfg_data;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (step) begin
            out_valid_next = res.valid;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    lssd_parse #(
        .EXT_BYTES     (EXT_BYTES),
        .SIZE_BITS     (SIZE_BITS),
        .MAX_SIGNATURE (MAX_SIGNATURE)
    ) u_parse (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .image_byte  (in_byte_reg),
        .frame_start (in_start_reg),
        .cfg         (cfg_reg),
        .res         (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_length    <= HDR_LEN_RST;
            cfg_reg.signature_length <= SIG_LEN_RST;
            cfg_reg.signature_chars  <= SIG_CHAR_RST;
            in_valid_reg             <= 1'b0;
            out_valid_reg            <= 1'b0;
        end else begin
            cfg_reg       <= cfg_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
        if (step && res.valid) begin
            out_kind_reg  <= res.kind;
            out_value_reg <= res.value;
            out_last_reg  <= res.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    // An error result always closes the stream
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_ERR)) |-> m_tlast)
        else $error("error result without last");

    // Extension bytes never end the stream
    a_ext_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_EXT)) |-> !m_tlast)
        else $error("extension byte marked last");

    // A size result is last exactly when the size is zero
    a_size_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_SIZE)) |-> (m_tlast == (m_tdata == '0)))
        else $error("size result last flag wrong");

    // With both registers full and the output stalled, no transaction is taken
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while pipeline full");

endmodule

/* design/lssd_parse.sv */
// Hidden-stream parser: header skip, LSB gathering and field sequencing.
`timescale 1ns / 1ps

module lssd_parse #(
    parameter int EXT_BYTES     = lssd_pkg::EXT_BYTES_DEF,
    parameter int SIZE_BITS     = lssd_pkg::SIZE_BITS_DEF,
    parameter int MAX_SIGNATURE = lssd_pkg::MAX_SIGNATURE_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic [lssd_pkg::BYTE_W-1:0]   image_byte,
    input  logic                          frame_start,
    input  lssd_pkg::cfg_t                cfg,
    output lssd_pkg::res_t                res
);
    import lssd_pkg::*;

    localparam int FMAX_A  = (EXT_BYTES > SIZE_BITS) ? EXT_BYTES : SIZE_BITS;
    localparam int FMAX    = (FMAX_A > MAX_SIGNATURE) ? FMAX_A : MAX_SIGNATURE;
    localparam int FIELD_W = $clog2(FMAX + 1);

    phase_t                 phase_reg, phase_next;
    logic [HDR_LEN_W-1:0]   hcnt_reg, hcnt_next;
    logic [2:0]             bit_reg, bit_next;
    logic [BYTE_W-1:0]      acc_reg, acc_next;
    logic [FIELD_W-1:0]     fidx_reg, fidx_next;
    logic [SIZE_BITS-1:0]   size_reg, size_next;
    logic [SIZE_BITS-1:0]   rem_reg, rem_next;

    // State as seen by this byte, after an optional restart
    phase_t                 eff_phase;
    logic [HDR_LEN_W-1:0]   eff_hcnt;
    logic [2:0]             eff_bit;
    logic [BYTE_W-1:0]      eff_acc;
    logic [FIELD_W-1:0]     eff_fidx;
    logic [SIZE_BITS-1:0]   eff_size;
    logic [SIZE_BITS-1:0]   eff_rem;

    logic [SIG_LEN_W-1:0]   slen;
    logic                   hdr_skip;
    phase_t                 work_phase;
    logic [FIELD_W-1:0]     work_fidx;
    logic                   active;
    logic                   group_done;
    logic [BYTE_W-1:0]      full;
    logic                   sig_pending;
    logic [SIG_SEL_W-1:0]   sig_sel;
    logic [BYTE_W-1:0]      sig_want;
    logic                   mismatch;
    logic [FIELD_W-1:0]     fidx_inc;
    logic [FIELD_W-1:0]     magic_fidx;
    logic                   magic_done;
    logic                   ext_done;
    logic                   size_done;
    logic [SIZE_BITS-1:0]   size_shift;
    logic [SIZE_BITS-1:0]   rem_dec;
    logic                   rem_zero;

    assign eff_phase = frame_start ? PH_HEADER : phase_reg;
    assign eff_hcnt  = frame_start ? '0 : hcnt_reg;
    assign eff_bit   = frame_start ? '0 : bit_reg;
    assign eff_acc   = frame_start ? '0 : acc_reg;
    assign eff_fidx  = frame_start ? '0 : fidx_reg;
    assign eff_size  = frame_start ? '0 : size_reg;
    assign eff_rem   = frame_start ? '0 : rem_reg;

    assign slen = (cfg.signature_length > SIG_LEN_W'(MAX_SIGNATURE))
                  ? SIG_LEN_W'(MAX_SIGNATURE) : cfg.signature_length;

    assign hdr_skip   = (eff_phase == PH_HEADER) && (eff_hcnt < cfg.header_length);
    assign work_phase = (eff_phase == PH_HEADER)
                        ? ((slen != '0) ? PH_MAGIC : PH_EXT) : eff_phase;
    assign work_fidx  = (eff_phase == PH_HEADER) ? '0 : eff_fidx;
    assign active     = !hdr_skip && (work_phase != PH_IDLE);

    assign full       = {eff_acc[BYTE_W-2:0], image_byte[0]};
    assign group_done = (eff_bit == 3'd7);

    // Signature: first character sits in the highest used byte
    assign sig_pending = work_fidx < FIELD_W'(slen);
    assign sig_sel     = SIG_SEL_W'(FIELD_W'(slen) - 1'b1 - work_fidx);
    assign sig_want    = cfg.signature_chars[sig_sel*BYTE_W +: BYTE_W];
    assign mismatch    = sig_pending && (full != sig_want);
    assign fidx_inc    = work_fidx + 1'b1;
    assign magic_fidx  = sig_pending ? fidx_inc : work_fidx;
    assign magic_done  = magic_fidx >= FIELD_W'(slen);

    assign ext_done   = fidx_inc >= FIELD_W'(EXT_BYTES);
    assign size_done  = fidx_inc >= FIELD_W'(SIZE_BITS);
    assign size_shift = {eff_size[SIZE_BITS-2:0], full[0]};
    assign rem_dec    = eff_rem - 1'b1;
    assign rem_zero   = (rem_dec == '0);

    // Next state
    always_comb begin
        phase_next = hdr_skip ? PH_HEADER : work_phase;
        hcnt_next  = hdr_skip ? eff_hcnt + 1'b1 : eff_hcnt;
        bit_next   = eff_bit;
        acc_next   = eff_acc;
        fidx_next  = hdr_skip ? eff_fidx : work_fidx;
        size_next  = eff_size;
        rem_next   = eff_rem;
        if (active) begin
            if (!group_done) begin
                bit_next = eff_bit + 1'b1;
                acc_next = full;
            end else begin
                bit_next = '0;
                acc_next = '0;
                case (work_phase)
                    PH_MAGIC: begin
                        if (mismatch) begin
                            phase_next = PH_IDLE;
                        end else if (magic_done) begin
                            fidx_next  = '0;
                            phase_next = PH_EXT;
                        end else begin
                            fidx_next = magic_fidx;
                        end
                    end
                    PH_EXT: begin
                        if (ext_done) begin
                            fidx_next  = '0;
                            phase_next = PH_SIZE;
                        end else begin
                            fidx_next = fidx_inc;
                        end
                    end
                    PH_SIZE: begin
                        size_next = size_shift;
                        if (size_done) begin
                            fidx_next  = '0;
                            rem_next   = size_shift;
                            phase_next = (size_shift == '0) ? PH_IDLE : PH_DATA;
                        end else begin
                            fidx_next = fidx_inc;
                        end
                    end
                    PH_DATA: begin
                        rem_next = rem_dec;
                        if (rem_zero) begin
                            phase_next = PH_IDLE;
                        end
                    end
                    default: begin
                        phase_next = work_phase;
                    end
                endcase
            end
        end
    end

    // Result for this byte
    always_comb begin
        res       = '0;
        res.kind  = KIND_EXT;
        res.value = VALUE_W'(full);
        if (active && group_done) begin
            case (work_phase)
                PH_MAGIC: begin
                    res.valid = mismatch;
                    res.kind  = KIND_ERR;
                    res.last  = 1'b1;
                end
                PH_EXT: begin
                    res.valid = 1'b1;
                    res.kind  = KIND_EXT;
                end
                PH_SIZE: begin
                    res.valid = size_done;
                    res.kind  = KIND_SIZE;
                    res.value = VALUE_W'(size_shift);
                    res.last  = (size_shift == '0);
                end
                PH_DATA: begin
                    res.valid = 1'b1;
                    res.kind  = KIND_DATA;
                    res.last  = rem_zero;
                end
                default: begin
                    res.valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            hcnt_reg  <= '0;
            bit_reg   <= '0;
            acc_reg   <= '0;
            fidx_reg  <= '0;
            size_reg  <= '0;
            rem_reg   <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            hcnt_reg  <= hcnt_next;
            bit_reg   <= bit_next;
            acc_reg   <= acc_next;
            fidx_reg  <= fidx_next;
            size_reg  <= size_next;
            rem_reg   <= rem_next;
        end
    end

endmodule

/* test/lssd_checker.sv */
// Scoreboard for the LSB stego stream decoder: parse prediction and result compare.
`timescale 1ns / 1ps

module lssd_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [lssd_pkg::BYTE_W-1:0]     s_tdata,
    input  logic                            s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [lssd_pkg::VALUE_W-1:0]    m_tdata,
    input  logic [lssd_pkg::KIND_W-1:0]     m_tuser,
    input  logic                            m_tlast,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [lssd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lssd_pkg::SIG_CHAR_W-1:0] cfg_data,
    output int                              errors,
    output int                              pending
);
    import lssd_pkg::*;

    localparam int EXT_BYTES     = EXT_BYTES_DEF;
    localparam int SIZE_BITS     = SIZE_BITS_DEF;
    localparam int MAX_SIGNATURE = MAX_SIGNATURE_DEF;
    localparam logic [VALUE_W-1:0] SIZE_MASK = {VALUE_W{1'b1}} >> (VALUE_W - SIZE_BITS);

    typedef struct {
        kind_t              kind;
        logic [VALUE_W-1:0] value;
        logic               last;
    } symbol_t;

    symbol_t expected_symbols[$];

    // programmed registers
    logic [HDR_LEN_W-1:0]  hdr_len;
    logic [SIG_LEN_W-1:0]  sig_len;
    logic [SIG_CHAR_W-1:0] sig_chars;

    // parser state
    phase_t             phase;
    logic [7:0]         hdr_cnt;
    logic [2:0]         bit_cnt;
    logic [7:0]         acc;
    logic [5:0]         field_idx;
    logic [VALUE_W-1:0] size_reg;
    logic [VALUE_W-1:0] data_left;

    int fail_cnt;

    function automatic int active_sig_len();
        return (sig_len > MAX_SIGNATURE) ? MAX_SIGNATURE : int'(sig_len);
    endfunction

    task automatic clear_parse();
        phase     = PH_HEADER;
        hdr_cnt   = '0;
        bit_cnt   = '0;
        acc       = '0;
        field_idx = '0;
        size_reg  = '0;
        data_left = '0;
    endtask

    task automatic add_expected(input kind_t k, input logic [VALUE_W-1:0] v, input logic l);
        symbol_t sym;
        sym.kind  = k;
        sym.value = v;
        sym.last  = l;
        expected_symbols.push_back(sym);
    endtask

    task automatic parse_image_byte(input logic [BYTE_W-1:0] pix, input logic restart);
        logic [7:0] full;
        logic [7:0] want;
        int         len;
        int         shift;
        if (restart)
            clear_parse();
        if (phase == PH_HEADER) begin
            if (hdr_cnt < hdr_len) begin
                hdr_cnt++;
                return;
            end
            field_idx = '0;
            phase = (active_sig_len() > 0) ? PH_MAGIC : PH_EXT;
        end
        if (phase == PH_IDLE)
            return;

        acc = {acc[6:0], pix[0]};
        if (bit_cnt < 3'd7) begin
            bit_cnt++;
            return;
        end
        bit_cnt = '0;
        full    = acc;
        acc     = '0;

        case (phase)
            PH_MAGIC: begin
                len = active_sig_len();
                if (field_idx < len) begin
                    shift = 8 * (len - 1 - int'(field_idx));
                    want  = sig_chars[shift +: 8];
                    if (full != want) begin
                        phase = PH_IDLE;
                        add_expected(KIND_ERR, VALUE_W'(full), 1'b1);
                        return;
                    end
                    field_idx++;
                end
                // a shortened signature ends here, this hidden byte is dropped
                if (field_idx >= len) begin
                    field_idx = '0;
                    phase     = PH_EXT;
                end
            end
            PH_EXT: begin
                field_idx++;
                if (field_idx >= EXT_BYTES) begin
                    field_idx = '0;
                    phase     = PH_SIZE;
                end
                add_expected(KIND_EXT, VALUE_W'(full), 1'b0);
            end
            PH_SIZE: begin
                size_reg = {size_reg[VALUE_W-2:0], full[0]} & SIZE_MASK;
                field_idx++;
                if (field_idx < SIZE_BITS)
                    return;
                field_idx = '0;
                data_left = size_reg;
                phase     = (size_reg == '0) ? PH_IDLE : PH_DATA;
                add_expected(KIND_SIZE, size_reg, size_reg == '0);
            end
            PH_DATA: begin
                data_left--;
                if (data_left == '0)
                    phase = PH_IDLE;
                add_expected(KIND_DATA, VALUE_W'(full), data_left == '0);
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        symbol_t oldest;
        if (!aresetn) begin
            hdr_len   = HDR_LEN_RST;
            sig_len   = SIG_LEN_RST;
            sig_chars = SIG_CHAR_RST;
            clear_parse();
            expected_symbols.delete();
            fail_cnt = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_symbols.size() == 0) begin
                    $error("unexpected result transaction: kind %0d value 0x%08h last %0b",
                           m_tuser, m_tdata, m_tlast);
                    fail_cnt++;
                end else begin
                    oldest = expected_symbols.pop_front();
                    if (m_tuser !== oldest.kind) begin
                        $error("kind mismatch: expected %0d, actual %0d", oldest.kind, m_tuser);
                        fail_cnt++;
                    end
                    if (m_tdata !== oldest.value) begin
                        $error("value mismatch: expected 0x%08h, actual 0x%08h",
                               oldest.value, m_tdata);
                        fail_cnt++;
                    end
                    if (m_tlast !== oldest.last) begin
                        $error("last mismatch: expected %0b, actual %0b", oldest.last, m_tlast);
                        fail_cnt++;
                    end
                end
            end

            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_index))
                    REG_HEADER_LENGTH:    hdr_len   = cfg_data[HDR_LEN_W-1:0];
                    REG_SIGNATURE_LENGTH: sig_len   = cfg_data[SIG_LEN_W-1:0];
                    REG_SIGNATURE_CHARS:  sig_chars = cfg_data;
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready)
                parse_image_byte(s_tdata, s_tuser);
        end
        errors  <= fail_cnt;
        pending <= expected_symbols.size();
    end

endmodule

/* test/tb.sv */
// Testbench top for the LSB stego stream decoder: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb;
    import lssd_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int TARGET_ITEMS = 1550;
    localparam int DRAIN_CYCLES = 4;
    localparam int MIN_RAND_FRAMES = 1;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [BYTE_W-1:0]     s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [VALUE_W-1:0]    m_tdata;
    logic [KIND_W-1:0]     m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [SIG_CHAR_W-1:0] cfg_data  = '0;

    int errors;
    int pending;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int bytes_sent    = 0;
    int quiet_cycles  = 0;
    logic frame_head  = 1'b0;   // next image byte carries frame_start

    // shadow of the programmed registers, used to build well-formed frames
    logic [HDR_LEN_W-1:0]  cur_hdr_len   = HDR_LEN_RST;
    logic [SIG_LEN_W-1:0]  cur_sig_len   = SIG_LEN_RST;
    logic [SIG_CHAR_W-1:0] cur_sig_chars = SIG_CHAR_RST;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    lsb_stego_stream_decoder i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lssd_checker i_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] pix);
        if (cfg_valid)
            cfg_valid <= 1'b0;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= pix;
        s_tuser    <= frame_head;
        frame_head = 1'b0;
        bytes_sent++;
        do @(posedge aclk); while (!s_tready);
    endtask

    // one hidden byte spread over the LSBs of eight image bytes, MSB first
    task automatic send_hidden(input logic [7:0] hidden);
        for (int i = 7; i >= 0; i--)
            send_byte({7'($urandom), hidden[i]});
    endtask

    task automatic send_header(input int count);
        repeat (count) send_byte(BYTE_W'($urandom));
    endtask

    task automatic send_body(input logic [VALUE_W-1:0] size, input int n_data);
        repeat (EXT_BYTES_DEF) send_hidden(8'($urandom));
        for (int i = SIZE_BITS_DEF - 1; i >= 0; i--)
            send_hidden({7'($urandom), size[i]});
        repeat (n_data) send_hidden(8'($urandom));
    endtask

    // bad_at < 0: clean signature, otherwise that character is corrupted
    task automatic send_frame(input int bad_at, input logic [VALUE_W-1:0] size,
                              input int n_data);
        int         n;
        logic [7:0] ch;
        n = (cur_sig_len > MAX_SIGNATURE_DEF) ? MAX_SIGNATURE_DEF : int'(cur_sig_len);
        if (bad_at >= n)
            bad_at = n - 1;
        frame_head = 1'b1;
        send_header(int'(cur_hdr_len));
        for (int k = 0; k < n; k++) begin
            ch = cur_sig_chars[8 * (n - 1 - k) +: 8];
            if (k == bad_at)
                ch ^= 8'($urandom_range(1, 255));
            send_hidden(ch);
            if (k == bad_at)
                break;
        end
        if (bad_at < 0)
            send_body(size, n_data);
        else
            send_header($urandom_range(0, 20));   // ignored after the error
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [SIG_CHAR_W-1:0] value);
        logic [SIG_CHAR_W-1:0] word;
        word = {$urandom, $urandom};
        case (idx)
            REG_HEADER_LENGTH: begin
                word[HDR_LEN_W-1:0] = value[HDR_LEN_W-1:0];
                cur_hdr_len = value[HDR_LEN_W-1:0];
            end
            REG_SIGNATURE_LENGTH: begin
                word[SIG_LEN_W-1:0] = value[SIG_LEN_W-1:0];
                cur_sig_len = value[SIG_LEN_W-1:0];
            end
            default: begin
                word = value;
                cur_sig_chars = value;
            end
        endcase
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // hold the sender until every expected result has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        logic [SIG_CHAR_W-1:0] chars;
        logic [VALUE_W-1:0]    size;
        int                    pick;
        int                    rand_frames;

        rand_frames = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 23;
        recv_idle_pct <= 45;

        // byte extremes and restarts inside the default header
        frame_head = 1'b1;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h01);
        frame_head = 1'b1;
        send_byte(8'hFE);
        send_byte(8'h80);
        send_byte(8'h7F);

        // reset settings: 54-byte header, two zero signature characters
        send_frame(-1, 32'd3, 3);

        // empty header, no signature, zero size, then bytes after the end
        drain();
        write_reg(REG_HEADER_LENGTH, 64'd0);
        write_reg(REG_SIGNATURE_LENGTH, 64'd0);
        write_reg(REG_SIGNATURE_CHARS, {$urandom, $urandom});
        send_frame(-1, 32'd0, 0);
        send_header(16);

        drain();
        send_idle_pct = 45;
        recv_idle_pct <= 23;

        // header length lowered below the bytes already skipped
        write_reg(REG_HEADER_LENGTH, 64'd40);
        write_reg(REG_SIGNATURE_LENGTH, 64'd3);
        chars = {$urandom, $urandom};
        write_reg(REG_SIGNATURE_CHARS, chars);
        frame_head = 1'b1;
        send_header(10);
        drain();
        write_reg(REG_HEADER_LENGTH, 64'd6);
        send_hidden(chars[23:16]);
        send_hidden(chars[15:8]);
        send_hidden(chars[7:0]);
        repeat (EXT_BYTES_DEF) send_hidden(8'($urandom));

        // signature shortened to the characters already matched
        drain();
        write_reg(REG_SIGNATURE_LENGTH, 64'd4);
        frame_head = 1'b1;
        send_header(int'(cur_hdr_len));
        send_hidden(chars[31:24]);
        send_hidden(chars[23:16]);
        drain();
        write_reg(REG_SIGNATURE_LENGTH, 64'd2);
        send_hidden(8'($urandom));
        repeat (EXT_BYTES_DEF) send_hidden(8'($urandom));

        // longest header, full signature of all ones, mismatch late
        drain();
        write_reg(REG_HEADER_LENGTH, 64'd255);
        write_reg(REG_SIGNATURE_LENGTH, 64'd8);
        write_reg(REG_SIGNATURE_CHARS, {SIG_CHAR_W{1'b1}});
        send_frame(5, 32'd0, 0);

        // length above the maximum counts as eight characters
        drain();
        write_reg(REG_HEADER_LENGTH, 64'd3);
        write_reg(REG_SIGNATURE_LENGTH, 64'd15);
        write_reg(REG_SIGNATURE_CHARS, {$urandom, $urandom});
        send_frame(7, 32'd0, 0);

        drain();
        send_idle_pct = 0;
        recv_idle_pct <= 0;

        while (bytes_sent < TARGET_ITEMS || rand_frames < MIN_RAND_FRAMES) begin
            drain();
            if ($urandom_range(2) == 0) begin
                write_reg(REG_HEADER_LENGTH, ($urandom_range(3) == 0) ? 64'd0 :
                          64'($urandom_range(1, 16)));
                write_reg(REG_SIGNATURE_LENGTH, 64'($urandom_range(0, 15)));
                write_reg(REG_SIGNATURE_CHARS, {$urandom, $urandom});
            end
            pick = $urandom_range(99);
            if (pick < 70) begin
                size = $urandom_range(1, 12);
                send_frame(-1, size, int'(size));
            end else if (pick < 85) begin
                send_frame($urandom_range(0, 7), 32'($urandom_range(1, 4)), 2);
            end else begin
                // huge size, cut short by the next frame start
                send_frame(-1, $urandom, $urandom_range(0, 4));
            end
            rand_frames++;
        end

        drain();
        if (errors == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* sim.f */
design/lssd_pkg.sv
design/lssd_parse.sv
design/lsb_stego_stream_decoder.sv
test/lssd_checker.sv
test/tb.sv
